/* rtl/core/sit_pkg.sv */
// shared codes for the segment intersection test
package sit_pkg;

	localparam int unsigned COORD_WIDTH_DEF = 16;

	typedef enum logic [1:0] {
		HC_NONE   = 2'd0,
		HC_CROSS  = 2'd1,
		HC_TOUCH  = 2'd2,
		HC_SHARED = 2'd3
	} hit_case_t;

	typedef enum logic [1:0] {
		TURN_COL = 2'd0,
		TURN_POS = 2'd1,
		TURN_NEG = 2'd2
	} turn_t;

endpackage

/* rtl/core/segment_intersection_test_top.sv */
// segment intersection test: four-stage pipeline from coordinates to verdict
//
// input channel: in_valid / in_ready carry one item, the eight coordinates of
// two segments. output channel: out_valid / out_ready carry hit and hit_case.
// an accepted item passes through stages 1, 2 and 3 into the output register,
// where the receiver takes its result at an edge with out_ready high. one item
// is taken every cycle while out_ready stays high; the rate is set by the stage
// chain, whose stages advance one item each whenever the stage after them is
// empty or moving:
//   stage 1: coordinate differences, shared endpoint and bounding box checks
//   stage 2: the eight products of the four cross products
//   stage 3: cross product subtraction and orientation sign
//   stage 4: output register with the final verdict
// when out_ready is low the output register holds its item, and the stages
// behind it fill one by one; in_ready drops only once all four hold items,
// so up to four items sit in the block and none is lost or repeated.
// reset (arst_n low) empties every stage at once; no results are pending
// after reset and in_ready is high from the first cycle.
module segment_intersection_test_top
	import sit_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] first_start_x,
	input  logic signed [COORD_WIDTH-1:0] first_start_y,
	input  logic signed [COORD_WIDTH-1:0] first_end_x,
	input  logic signed [COORD_WIDTH-1:0] first_end_y,
	input  logic signed [COORD_WIDTH-1:0] second_start_x,
	input  logic signed [COORD_WIDTH-1:0] second_start_y,
	input  logic signed [COORD_WIDTH-1:0] second_end_x,
	input  logic signed [COORD_WIDTH-1:0] second_end_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic [1:0]                    hit_case
);

	localparam int unsigned DW = COORD_WIDTH + 1;
	localparam int unsigned PW = 2 * DW;
	localparam int unsigned TW = PW + 1;

	function automatic logic signed [DW-1:0] sdiff(
		input logic signed [COORD_WIDTH-1:0] p,
		input logic signed [COORD_WIDTH-1:0] q
	);
		sdiff = $signed({p[COORD_WIDTH-1], p}) - $signed({q[COORD_WIDTH-1], q});
	endfunction

	// m lies between a and b, bounds included
	function automatic logic in_rng(
		input logic signed [COORD_WIDTH-1:0] m,
		input logic signed [COORD_WIDTH-1:0] a,
		input logic signed [COORD_WIDTH-1:0] b
	);
		in_rng = (m <= a || m <= b) && (m >= a || m >= b);
	endfunction

	// stage advance chain
	logic adv1, adv2, adv3, adv4;
	logic vld_s1, vld_s2, vld_s3, out_valid_q;

	assign adv4 = !out_valid_q || out_ready;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign in_ready = adv1;

	// stage 1: cross product k is ea*eb - ec*ed
	logic signed [DW-1:0] ea_c [4];
	logic signed [DW-1:0] eb_c [4];
	logic signed [DW-1:0] ec_c [4];
	logic signed [DW-1:0] ed_c [4];
	logic [3:0]           box_c;
	logic                 rej_c;
	logic                 eq00, eq01, eq10, eq11;

	always_comb begin
		ea_c[0] = sdiff(first_end_y, first_start_y);
		ec_c[0] = sdiff(first_end_x, first_start_x);
		eb_c[0] = sdiff(second_start_x, first_end_x);
		ed_c[0] = sdiff(second_start_y, first_end_y);
		ea_c[1] = ea_c[0];
		ec_c[1] = ec_c[0];
		eb_c[1] = sdiff(second_end_x, first_end_x);
		ed_c[1] = sdiff(second_end_y, first_end_y);
		ea_c[2] = sdiff(second_end_y, second_start_y);
		ec_c[2] = sdiff(second_end_x, second_start_x);
		eb_c[2] = sdiff(first_start_x, second_end_x);
		ed_c[2] = sdiff(first_start_y, second_end_y);
		ea_c[3] = ea_c[2];
		ec_c[3] = ec_c[2];
		eb_c[3] = sdiff(first_end_x, second_end_x);
		ed_c[3] = sdiff(first_end_y, second_end_y);

		box_c[0] = in_rng(second_start_x, first_start_x, first_end_x)
			&& in_rng(second_start_y, first_start_y, first_end_y);
		box_c[1] = in_rng(second_end_x, first_start_x, first_end_x)
			&& in_rng(second_end_y, first_start_y, first_end_y);
		box_c[2] = in_rng(first_start_x, second_start_x, second_end_x)
			&& in_rng(first_start_y, second_start_y, second_end_y);
		box_c[3] = in_rng(first_end_x, second_start_x, second_end_x)
			&& in_rng(first_end_y, second_start_y, second_end_y);

		eq00 = first_start_x == second_start_x && first_start_y == second_start_y;
		eq01 = first_start_x == second_end_x && first_start_y == second_end_y;
		eq10 = first_end_x == second_start_x && first_end_y == second_start_y;
		eq11 = first_end_x == second_end_x && first_end_y == second_end_y;
		// one pair of endpoints coincides and the opposite pair does not
		rej_c = (eq00 && !eq11) || (eq01 && !eq10) || (eq10 && !eq01) || (eq11 && !eq00);
	end

	logic signed [DW-1:0] ea_s1 [4];
	logic signed [DW-1:0] eb_s1 [4];
	logic signed [DW-1:0] ec_s1 [4];
	logic signed [DW-1:0] ed_s1 [4];
	logic [3:0]           box_s1;
	logic                 rej_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			ea_s1  <= ea_c;
			eb_s1  <= eb_c;
			ec_s1  <= ec_c;
			ed_s1  <= ed_c;
			box_s1 <= box_c;
			rej_s1 <= rej_c;
		end
	end

	// stage 2: products
	logic signed [PW-1:0] pab_s2 [4];
	logic signed [PW-1:0] pcd_s2 [4];
	logic [3:0]           box_s2;
	logic                 rej_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int k = 0; k < 4; k++) begin
				pab_s2[k] <= ea_s1[k] * eb_s1[k];
				pcd_s2[k] <= ec_s1[k] * ed_s1[k];
			end
			box_s2 <= box_s1;
			rej_s2 <= rej_s1;
		end
	end

	// stage 3: orientation signs
	logic signed [TW-1:0] cross_c [4];
	turn_t                turn_c  [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cross_c[k] = $signed({pab_s2[k][PW-1], pab_s2[k]})
				- $signed({pcd_s2[k][PW-1], pcd_s2[k]});
			if (cross_c[k] == '0) begin
				turn_c[k] = TURN_COL;
			end else if (cross_c[k][TW-1]) begin
				turn_c[k] = TURN_NEG;
			end else begin
				turn_c[k] = TURN_POS;
			end
		end
	end

	turn_t      turn_s3 [4];
	logic [3:0] box_s3;
	logic       rej_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			turn_s3 <= turn_c;
			box_s3  <= box_s2;
			rej_s3  <= rej_s2;
		end
	end

	// stage 4: verdict into the output register
	hit_case_t case_c;
	logic      crossing, touching;

	always_comb begin
		crossing = (turn_s3[0] != turn_s3[1]) && (turn_s3[2] != turn_s3[3]);
		touching = (turn_s3[0] == TURN_COL && box_s3[0])
			|| (turn_s3[1] == TURN_COL && box_s3[1])
			|| (turn_s3[2] == TURN_COL && box_s3[2])
			|| (turn_s3[3] == TURN_COL && box_s3[3]);
		if (rej_s3) begin
			case_c = HC_SHARED;
		end else if (crossing) begin
			case_c = HC_CROSS;
		end else if (touching) begin
			case_c = HC_TOUCH;
		end else begin
			case_c = HC_NONE;
		end
	end

	hit_case_t hit_case_q;
	logic      hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv4) begin
			out_valid_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			hit_case_q <= case_c;
			hit_q      <= (case_c == HC_CROSS) || (case_c == HC_TOUCH);
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign hit_case  = hit_case_q;

endmodule

/* rtl/core/sit_check.sv */
// port-level checks for the segment intersection test, bound to the top level
module sit_check
	import sit_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       hit,
	input logic [1:0] hit_case
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_case))
		else $error("stalled result changed or vanished");

	// hit agrees with the verdict code
	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hit == (hit_case == HC_CROSS || hit_case == HC_TOUCH))
		else $error("hit disagrees with hit_case");

	// input side only blocks when the pipeline is full behind a stalled output
	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without a stalled output");

	// a rising out_valid must go back to an item that entered and passed through every stage
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 4))
		else $error("result appeared without an item four cycles before");

endmodule

bind segment_intersection_test_top sit_check u_sit_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.hit       (hit),
	.hit_case  (hit_case)
);
